FILE: rtl/core/els_pkg.sv
// shared widths, constants and pipeline word types for the ellipse outline scan
package els_pkg;

  localparam int C_BITS   = 10;                 // coordinate width
  localparam int F_BITS   = 16;                 // fraction bits
  localparam int RT_W     = C_BITS + F_BITS;    // root, center and increment width
  localparam int N_W      = 2 * C_BITS;         // radicand width
  localparam int SREM_W   = RT_W + 2;           // square root remainder width
  localparam int PR_W     = C_BITS + RT_W;      // product width
  localparam int DV_W     = C_BITS + 1;         // divisor width (2*w)
  localparam int DREM_W   = DV_W + 1;           // divider remainder width
  localparam int LATENCY  = 2 * RT_W + 3;       // cycles from accept to result strobe

  // per-word data that rides along the whole pipeline
  typedef struct packed {
    logic              oos;
    logic              wz;
    logic [C_BITS-1:0] h;
    logic [DV_W-1:0]   vdiv;
    logic [RT_W-1:0]   center;
  } side_t;

  // square root cell word
  typedef struct packed {
    logic              valid;
    side_t             side;
    logic [N_W-1:0]    n;
    logic [RT_W-1:0]   root;
    logic [SREM_W-1:0] rem;
  } sq_t;

  // divider cell word
  typedef struct packed {
    logic              valid;
    side_t             side;
    logic [PR_W-1:0]   p;
    logic [RT_W-1:0]   q;
    logic [DREM_W-1:0] rem;
  } dv_t;

endpackage

FILE: rtl/core/els_sqrt_cell.sv
// one digit of the square root chain
module els_sqrt_cell import els_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  sq_t        d_in,
  input  logic [1:0] two,
  output sq_t        d_out
);

  sq_t               word_r, word_nxt;
  logic [SREM_W-1:0] remx, trial;

  // bring down one pair and try the trial subtraction
  always_comb begin
    word_nxt = d_in;
    remx     = {d_in.rem[SREM_W-3:0], two};
    trial    = {d_in.root, 2'b01};
    if (remx >= trial) begin
      word_nxt.rem  = remx - trial;
      word_nxt.root = {d_in.root[RT_W-2:0], 1'b1};
    end else begin
      word_nxt.rem  = remx;
      word_nxt.root = {d_in.root[RT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
    end else begin
      word_r <= word_nxt;
    end
  end

  assign d_out = word_r;

endmodule

FILE: rtl/core/els_div_cell.sv
// one quotient bit of the divider chain
module els_div_cell import els_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  dv_t  d_in,
  input  logic pbit,
  output dv_t  d_out
);

  dv_t               word_r, word_nxt;
  logic [DREM_W-1:0] remx, dvs;

  // shift in one dividend bit, subtract divisor when it fits
  always_comb begin
    word_nxt = d_in;
    remx     = {d_in.rem[DREM_W-2:0], pbit};
    dvs      = {1'b0, d_in.side.vdiv};
    if (remx >= dvs) begin
      word_nxt.rem = remx - dvs;
      word_nxt.q   = {d_in.q[RT_W-2:0], 1'b1};
    end else begin
      word_nxt.rem = remx;
      word_nxt.q   = {d_in.q[RT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
    end else begin
      word_r <= word_nxt;
    end
  end

  assign d_out = word_r;

endmodule

FILE: rtl/core/ellipse_outline_scan.sv
// top level: corner sort, square root chain, multiply, divider chain, rounding
// a word passes the front register, the root cells, the multiply register, the divider cells and the output register
// throughput: one word per cycle, busy is never raised
// the chains hold one root digit and one quotient bit per cell
// results strobe out_valid for a single cycle; the receiver cannot stall
// reset is synchronous, active low, and clears the pipeline words and out_valid
module ellipse_outline_scan import els_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [C_BITS-1:0] in_corner_ax,
  input  logic [C_BITS-1:0] in_corner_ay,
  input  logic [C_BITS-1:0] in_corner_bx,
  input  logic [C_BITS-1:0] in_corner_by,
  input  logic              in_op,
  input  logic [C_BITS-1:0] in_scan_pos,
  output logic              out_valid,
  output logic [C_BITS-1:0] out_coord_plus,
  output logic [C_BITS-1:0] out_coord_minus,
  output logic              out_out_of_span
);

  sq_t               sq_r, sq_nxt;
  sq_t               sq_ch [RT_W+1];
  dv_t               dv_r, dv_nxt;
  dv_t               dv_ch [RT_W+1];
  logic [C_BITS-1:0] s0, s1, o0, o1, lo, hi, olo, ohi, w;
  logic [C_BITS:0]   twice, sum, dd;
  logic [N_W-1:0]    ww, ddsq;
  logic              valid_r, plus_nxt_oos;
  logic [C_BITS-1:0] plus_r, minus_r;
  logic              oos_r;
  logic [RT_W-1:0]   inc;
  logic [RT_W:0]     half, psum, msum;

  assign busy = 1'b0;

  // front end: pick axes, sort corners, form radicand
  always_comb begin
    s0 = in_op ? in_corner_ay : in_corner_ax;
    s1 = in_op ? in_corner_by : in_corner_bx;
    o0 = in_op ? in_corner_ax : in_corner_ay;
    o1 = in_op ? in_corner_bx : in_corner_by;
    lo  = (s0 < s1) ? s0 : s1;
    hi  = (s0 < s1) ? s1 : s0;
    olo = (o0 < o1) ? o0 : o1;
    ohi = (o0 < o1) ? o1 : o0;
    w     = hi - lo;
    twice = {in_scan_pos, 1'b0};
    sum   = {1'b0, lo} + {1'b0, hi};
    dd    = (twice >= sum) ? (twice - sum) : (sum - twice);
    ww    = w * w;
    ddsq  = dd[C_BITS-1:0] * dd[C_BITS-1:0];
    sq_nxt                  = '0;
    sq_nxt.valid            = start;
    sq_nxt.side.oos         = (in_scan_pos < lo) || (in_scan_pos > hi);
    sq_nxt.side.wz          = (w == '0);
    sq_nxt.side.h           = ohi - olo;
    sq_nxt.side.vdiv        = {w, 1'b0};
    sq_nxt.side.center      = RT_W'(({1'b0, olo} + {1'b0, ohi})) << (F_BITS - 1);
    sq_nxt.n                = ww - ddsq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r <= '0;
    end else begin
      sq_r <= sq_nxt;
    end
  end

  // square root chain, one digit per cell
  assign sq_ch[0] = sq_r;
  for (genvar k = 0; k < RT_W; k++) begin : g_sq
    localparam int I = RT_W - 1 - k;
    logic [1:0] two;
    if (I >= F_BITS) begin : g_pair
      assign two = sq_ch[k].n[2*(I-F_BITS) +: 2];
    end else begin : g_zero
      assign two = 2'b00;
    end
    els_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (sq_ch[k]),
      .two   (two),
      .d_out (sq_ch[k+1])
    );
  end

  // multiply height by root
  always_comb begin
    dv_nxt       = '0;
    dv_nxt.valid = sq_ch[RT_W].valid;
    dv_nxt.side  = sq_ch[RT_W].side;
    dv_nxt.p     = PR_W'(sq_ch[RT_W].side.h) * PR_W'(sq_ch[RT_W].root);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
    end else begin
      dv_r <= dv_nxt;
    end
  end

  // divider chain, one quotient bit per cell
  always_comb begin
    dv_ch[0]     = dv_r;
    dv_ch[0].rem = DREM_W'(dv_r.p[PR_W-1:RT_W]);
  end

  for (genvar k = 0; k < RT_W; k++) begin : g_dv
    els_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (dv_ch[k]),
      .pbit  (dv_ch[k].p[RT_W-1-k]),
      .d_out (dv_ch[k+1])
    );
  end

  // round half up around the center
  always_comb begin
    inc  = (dv_ch[RT_W].side.oos || dv_ch[RT_W].side.wz) ? '0 : dv_ch[RT_W].q;
    half = (RT_W+1)'(1) << (F_BITS - 1);
    psum = {1'b0, dv_ch[RT_W].side.center} + {1'b0, inc} + half;
    msum = {1'b0, dv_ch[RT_W].side.center} - {1'b0, inc} + half;
    plus_nxt_oos = dv_ch[RT_W].side.oos;
  end

  always_ff @(posedge clk) begin
    plus_r  <= psum[F_BITS +: C_BITS];
    minus_r <= msum[F_BITS +: C_BITS];
    oos_r   <= plus_nxt_oos;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= dv_ch[RT_W].valid;
    end
  end

  assign out_valid       = valid_r;
  assign out_coord_plus  = plus_r;
  assign out_coord_minus = minus_r;
  assign out_out_of_span = oos_r;

  // a result only follows an accepted word
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LATENCY))
    else $error("result without matching input word");

  // outside the span both coordinates are the center
  a_oos_center: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_span) |-> (out_coord_plus == out_coord_minus))
    else $error("out of span result not centered");

  // block never stalls the sender
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised");

endmodule
